[sv/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int unsigned HeaderBytes = 6;
	localparam int unsigned CountW      = 3;
	localparam int unsigned LengthW     = 32;
	localparam int unsigned TypeW       = 16;
	localparam int unsigned ByteW       = 8;

	// header byte positions
	localparam logic [CountW-1:0] HdrLenFirst  = CountW'(0);
	localparam logic [CountW-1:0] HdrTypeFirst = CountW'(4);
	localparam logic [CountW-1:0] HdrLast      = CountW'(HeaderBytes - 1);

	typedef struct packed {
		logic [TypeW-1:0]   msg_type;
		logic [LengthW-1:0] msg_length;
		logic               has_byte;
		logic [ByteW-1:0]   payload_byte;
		logic               first_of_message;
		logic               last_of_message;
	} lpd_result_t;

endpackage

[sv/lpd_parser.sv]
// ----------------------------------------------------------------------------
// lpd_parser
// Header/payload tracking state; builds the result for the byte taken now.
// ----------------------------------------------------------------------------
module lpd_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [lpd_pkg::ByteW-1:0] in_byte,
	output logic                     res_valid,
	output lpd_pkg::lpd_result_t     res
);
	import lpd_pkg::*;

	logic [CountW-1:0]  header_count_q;
	logic [LengthW-1:0] length_accum_q;
	logic [TypeW-1:0]   type_accum_q;
	logic [LengthW-1:0] bytes_remaining_q;
	logic               first_pending_q;

	logic [CountW-1:0]  header_count_d;
	logic [LengthW-1:0] length_accum_d;
	logic [TypeW-1:0]   type_accum_d;
	logic [LengthW-1:0] bytes_remaining_d;
	logic               first_pending_d;
	logic               in_payload;
	logic               hdr_done;

	assign in_payload = (bytes_remaining_q != '0);
	// counts past the last position behave like the last header byte
	assign hdr_done   = (header_count_q >= HdrLast);

	always_comb begin
		header_count_d    = header_count_q;
		length_accum_d    = length_accum_q;
		type_accum_d      = type_accum_q;
		bytes_remaining_d = bytes_remaining_q;
		first_pending_d   = first_pending_q;
		res_valid         = 1'b0;
		res               = '0;
		res.msg_type      = type_accum_q;
		res.msg_length    = length_accum_q;
		if (in_payload) begin
			res_valid            = 1'b1;
			res.has_byte         = 1'b1;
			res.payload_byte     = in_byte;
			res.first_of_message = first_pending_q;
			res.last_of_message  = (bytes_remaining_q == LengthW'(1));
			first_pending_d      = 1'b0;
			bytes_remaining_d    = bytes_remaining_q - LengthW'(1);
		end else begin
			if (header_count_q == HdrLenFirst) begin
				length_accum_d = LengthW'(in_byte);
			end else if (header_count_q < HdrTypeFirst) begin
				length_accum_d = {length_accum_q[LengthW-ByteW-1:0], in_byte};
			end else if (header_count_q == HdrTypeFirst) begin
				type_accum_d = TypeW'(in_byte);
			end else begin
				type_accum_d = {type_accum_q[TypeW-ByteW-1:0], in_byte};
			end
			if (!hdr_done) begin
				header_count_d = header_count_q + CountW'(1);
			end else begin
				header_count_d = '0;
				if (length_accum_d == '0) begin
					// empty message: one marker result, no byte
					res_valid            = 1'b1;
					res.msg_type         = type_accum_d;
					res.msg_length       = '0;
					res.first_of_message = 1'b1;
					res.last_of_message  = 1'b1;
					first_pending_d      = 1'b0;
				end else begin
					bytes_remaining_d = length_accum_d;
					first_pending_d   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q    <= '0;
			length_accum_q    <= '0;
			type_accum_q      <= '0;
			bytes_remaining_q <= '0;
			first_pending_q   <= 1'b0;
		end else if (take) begin
			header_count_q    <= header_count_d;
			length_accum_q    <= length_accum_d;
			type_accum_q      <= type_accum_d;
			bytes_remaining_q <= bytes_remaining_d;
			first_pending_q   <= first_pending_d;
		end
	end

endmodule

[sv/length_prefix_deframer_unit.sv]
// ----------------------------------------------------------------------------
// length_prefix_deframer_unit
// Splits a byte stream into length-prefixed messages and tags payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_byte) takes one stream byte per
//   item. Each message is a 6-byte header (4-byte big-endian length, 2-byte
//   big-endian type) followed by its payload; messages may be split or joined
//   anywhere in the stream.
//   Output channel (out_valid / out_stall / fields) gives one item per payload
//   byte, tagged with type, length and first/last flags. Header bytes give no
//   item, except that an empty message gives one item with has_byte low and
//   both flags high.
//   Each result is registered in the output register, or in the skid register
//   if the output stalls. Throughput: one byte per cycle while in_stall is low,
//   set by the single register stage updating the header and payload counters.
//   When the receiver stalls, the output register holds and a one-entry skid
//   register catches the next result; in_stall rises only once the skid is
//   full, so in_stall is a registered signal.
//   Reset clears the header counter and all valids; the block then expects
//   a header byte.
// ----------------------------------------------------------------------------
module length_prefix_deframer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lpd_pkg::ByteW-1:0]   in_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lpd_pkg::TypeW-1:0]   msg_type,
	output logic [lpd_pkg::LengthW-1:0] msg_length,
	output logic                       has_byte,
	output logic [lpd_pkg::ByteW-1:0]   payload_byte,
	output logic                       first_of_message,
	output logic                       last_of_message
);
	import lpd_pkg::*;

	logic        in_take;
	logic        out_take;
	logic        res_valid;
	lpd_result_t res;
	logic        out_vld_q;
	lpd_result_t out_q;
	logic        skid_vld_q;
	lpd_result_t skid_q;
	logic        out_free;

	assign in_stall = skid_vld_q;
	assign in_take  = in_valid & ~skid_vld_q;
	assign out_take = out_vld_q & ~out_stall;
	assign out_free = out_take | ~out_vld_q;

	lpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_take),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			// refill from skid first, else from the new result
			out_vld_q  <= skid_vld_q | (in_take & res_valid);
			skid_vld_q <= 1'b0;
		end else if (in_take && res_valid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (in_take && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid        = out_vld_q;
	assign msg_type         = out_q.msg_type;
	assign msg_length       = out_q.msg_length;
	assign has_byte         = out_q.has_byte;
	assign payload_byte     = out_q.payload_byte;
	assign first_of_message = out_q.first_of_message;
	assign last_of_message  = out_q.last_of_message;

endmodule

[bench/lpd_stream_checker.sv]
// ----------------------------------------------------------------------------
// lpd_stream_checker
// Watches both channels of the deframer, rebuilds the message framing from
// every accepted stream byte and compares each output item with it.
// ----------------------------------------------------------------------------
module lpd_stream_checker
	import lpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [ByteW-1:0]   in_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [TypeW-1:0]   msg_type,
	input  logic [LengthW-1:0] msg_length,
	input  logic               has_byte,
	input  logic [ByteW-1:0]   payload_byte,
	input  logic               first_of_message,
	input  logic               last_of_message,
	output int unsigned        errors,
	output int unsigned        waiting,
	output int unsigned        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CountW-1:0]  hdr_pos   = HdrLenFirst;
	logic [LengthW-1:0] len_word  = '0;
	logic [TypeW-1:0]   type_word = '0;
	logic [LengthW-1:0] left      = '0;
	logic               first_due = 1'b0;

	lpd_result_t due_results[$];
	int unsigned err_cnt = 0;
	int unsigned ok_cnt  = 0;

	// advance the framing by one stream byte, queue the item it causes
	function automatic void frame_byte(input logic [ByteW-1:0] b);
		lpd_result_t r;
		if (left != '0) begin
			r.msg_type         = type_word;
			r.msg_length       = len_word;
			r.has_byte         = 1'b1;
			r.payload_byte     = b;
			r.first_of_message = first_due;
			r.last_of_message  = (left == LengthW'(1));
			due_results.push_back(r);
			first_due = 1'b0;
			left      = left - LengthW'(1);
		end else begin
			if (hdr_pos == HdrLenFirst)
				len_word = LengthW'(b);
			else if (hdr_pos < HdrTypeFirst)
				len_word = {len_word[LengthW-ByteW-1:0], b};
			else if (hdr_pos == HdrTypeFirst)
				type_word = TypeW'(b);
			else
				type_word = {type_word[TypeW-ByteW-1:0], b};

			if (hdr_pos < HdrLast) begin
				hdr_pos = hdr_pos + CountW'(1);
			end else begin
				hdr_pos = HdrLenFirst;
				if (len_word == '0) begin
					// empty message: one item with no byte, both flags set
					r.msg_type         = type_word;
					r.msg_length       = '0;
					r.has_byte         = 1'b0;
					r.payload_byte     = '0;
					r.first_of_message = 1'b1;
					r.last_of_message  = 1'b1;
					due_results.push_back(r);
					first_due = 1'b0;
				end else begin
					left      = len_word;
					first_due = 1'b1;
				end
			end
		end
	endfunction

	task automatic cmp_field(input string name, input logic [LengthW-1:0] want,
			input logic [LengthW-1:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		lpd_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					err_cnt++;
					$display("%0t: item with nothing pending, expected none, got type %0h len %0h byte %0h",
						$time, msg_type, msg_length, payload_byte);
				end else begin
					want = due_results.pop_front();
					cmp_field("msg_type", LengthW'(want.msg_type), LengthW'(msg_type));
					cmp_field("msg_length", want.msg_length, msg_length);
					cmp_field("has_byte", LengthW'(want.has_byte), LengthW'(has_byte));
					cmp_field("payload_byte", LengthW'(want.payload_byte),
						LengthW'(payload_byte));
					cmp_field("first_of_message", LengthW'(want.first_of_message),
						LengthW'(first_of_message));
					cmp_field("last_of_message", LengthW'(want.last_of_message),
						LengthW'(last_of_message));
					ok_cnt++;
				end
			end
			if (in_valid && !in_stall)
				frame_byte(in_byte);
		end
		errors  <= err_cnt;
		waiting <= due_results.size();
		checked <= ok_cnt;
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Feeds the deframer a stream of length-prefixed messages under changing
// sender gaps and receiver stalls; the checker judges every output item.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [lpd_pkg::ByteW-1:0]    in_byte   = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [lpd_pkg::TypeW-1:0]    msg_type;
	logic [lpd_pkg::LengthW-1:0]  msg_length;
	logic                         has_byte;
	logic [lpd_pkg::ByteW-1:0]    payload_byte;
	logic                         first_of_message;
	logic                         last_of_message;

	int unsigned errors;
	int unsigned waiting;
	int unsigned checked;

	int unsigned stall_pct = 85;
	logic [7:0]  stream[$];
	int unsigned n_msgs  = 0;
	int unsigned n_empty = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	length_prefix_deframer_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.msg_type         (msg_type),
		.msg_length       (msg_length),
		.has_byte         (has_byte),
		.payload_byte     (payload_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message)
	);

	lpd_stream_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.msg_type         (msg_type),
		.msg_length       (msg_length),
		.has_byte         (has_byte),
		.payload_byte     (payload_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.errors           (errors),
		.waiting          (waiting),
		.checked          (checked)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic add_header(input logic [31:0] len, input logic [15:0] kind);
		stream.push_back(len[31:24]);
		stream.push_back(len[23:16]);
		stream.push_back(len[15:8]);
		stream.push_back(len[7:0]);
		stream.push_back(kind[15:8]);
		stream.push_back(kind[7:0]);
		n_msgs++;
		if (len == 0)
			n_empty++;
	endtask

	initial begin : stimulus
		int unsigned idle_pct;
		int unsigned total;
		int unsigned len;
		int unsigned roll;

		// directed: empty message, one-byte message, short message with edge values
		add_header(32'd0, 16'hFFFF);
		add_header(32'd1, 16'h0000);
		stream.push_back(8'hFF);
		add_header(32'd3, 16'h8001);
		stream.push_back(8'h00);
		stream.push_back(8'h55);
		stream.push_back(8'hAA);

		// random messages, joined back to back; gaps split them anywhere
		while (stream.size() < 1030) begin
			roll = $urandom_range(99);
			if (roll < 12)
				len = 0;
			else if (roll < 70)
				len = $urandom_range(8, 1);
			else if (roll < 95)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(300, 100);
			add_header(len, 16'($urandom_range(16'hFFFF)));
			repeat (len)
				stream.push_back(8'($urandom_range(255)));
		end

		// largest length: the stream ends inside this message
		add_header(32'hFFFF_FFFF, 16'($urandom_range(16'hFFFF)));
		repeat (20)
			stream.push_back(8'($urandom_range(255)));
		total = stream.size();

		idle_pct = 35;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < total; i++) begin
			if (i == total / 3) begin
				idle_pct = 85;
				stall_pct <= 35;
			end else if (i == 2 * total / 3) begin
				idle_pct = 0;
				stall_pct <= 0;
			end
			if ($urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(99) < idle_pct);
			end
			in_valid <= 1'b1;
			in_byte  <= stream[i];
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d stream bytes in %0d messages (%0d empty), the last one left open",
			total, n_msgs, n_empty);
		$display("Compared %0d output items under three sender/receiver stall patterns",
			checked);
		if (errors == 0 && waiting == 0) begin
			$display("All tests passed");
		end else begin
			if (waiting != 0)
				$display("%0t: %0d expected items never arrived", $time, waiting);
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#400_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
